// ----- src/rpra_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the ring pair resource arbiter.
// Used by rpra_cell and by the top level; depends on nothing else.
package rpra_pkg;

  localparam int unsigned WAIT_W   = 24;
  localparam int unsigned USE_W    = 16;
  localparam int unsigned SUM_W    = 32;
  localparam int unsigned MASK_W   = 16;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned REQ_W    = 4;
  localparam int unsigned ACTIVE_W = 5;
  localparam int unsigned CFG_W    = 24;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd5;
  localparam logic [WAIT_W-1:0]   THR_RESET    = 24'd3000;
  localparam int unsigned         RING_MIN     = 5;

  localparam logic [WAIT_W-1:0] WAIT_MAX = {WAIT_W{1'b1}};
  localparam logic [USE_W-1:0]  USE_MAX  = {USE_W{1'b1}};
  localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_HOLD   = 2'd1,
    PH_HUNGRY = 2'd2
  } phase_t;

  typedef enum logic [OP_W-1:0] {
    OP_TICK    = 2'd0,
    OP_REQUEST = 2'd1,
    OP_RELEASE = 2'd2
  } op_t;

  typedef enum logic {
    CFG_ACTIVE_COUNT   = 1'b0,
    CFG_WAIT_THRESHOLD = 1'b1
  } cfg_idx_t;

  // Event decoded for one cell.
  typedef struct packed {
    logic en;
    logic tick;
    logic req;
    logic rel;
  } cell_cmd_t;

  // What a cell shows its neighbours in the cycle an item is taken.
  typedef struct packed {
    phase_t            phase;
    logic [WAIT_W-1:0] wait_ticks;
    logic              released;
    logic              grant;
  } cell_link_t;

  // Next-state view of a cell, used for the result.
  typedef struct packed {
    phase_t           phase;
    logic             free;
    logic [USE_W-1:0] uses;
    logic [SUM_W-1:0] sum;
  } cell_view_t;

  function automatic logic outranks(input cell_link_t nb, input logic [WAIT_W-1:0] self_wait,
                                    input logic [WAIT_W-1:0] thr);
    return (nb.phase == PH_HUNGRY) && (nb.wait_ticks > self_wait) && (nb.wait_ticks > thr);
  endfunction

endpackage

// ----- src/rpra_cell.sv -----
`timescale 1ns / 1ps
// One requester of the ring with the resource on its left side.
// Depends on rpra_pkg.
module rpra_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rpra_pkg::cell_cmd_t            cmd,
  input  logic [rpra_pkg::WAIT_W-1:0]    threshold,
  input  rpra_pkg::cell_link_t           left,
  input  rpra_pkg::cell_link_t           right,
  output rpra_pkg::cell_link_t           link_o,
  output rpra_pkg::cell_view_t           view_o
);

  rpra_pkg::phase_t                phase_r, phase_nxt, phase_pre;
  logic [rpra_pkg::WAIT_W-1:0]     wait_r, wait_nxt, wait_pre;
  logic [rpra_pkg::USE_W-1:0]      uses_r, uses_nxt;
  logic [rpra_pkg::SUM_W-1:0]      sum_r, sum_nxt;
  logic                            free_r, free_nxt;
  logic                            req_eff, rel_eff, attempt, grant;
  logic [rpra_pkg::SUM_W:0]        sum_ext;

  assign req_eff = cmd.req && (phase_r == rpra_pkg::PH_IDLE);
  assign rel_eff = cmd.rel && (phase_r == rpra_pkg::PH_HOLD);

  always_comb begin
    phase_pre = phase_r;
    wait_pre  = wait_r;
    if (req_eff) begin
      phase_pre = rpra_pkg::PH_HUNGRY;
      wait_pre  = '0;
    end else if (rel_eff) begin
      phase_pre = rpra_pkg::PH_IDLE;
    end
  end

  assign attempt = req_eff || (cmd.en && (left.released || right.released));
  assign grant   = attempt && (phase_pre == rpra_pkg::PH_HUNGRY) &&
                   (left.phase != rpra_pkg::PH_HOLD) && (right.phase != rpra_pkg::PH_HOLD) &&
                   !rpra_pkg::outranks(left, wait_pre, threshold) &&
                   !rpra_pkg::outranks(right, wait_pre, threshold);

  assign sum_ext = {1'b0, sum_r} + {{(rpra_pkg::SUM_W + 1 - rpra_pkg::WAIT_W){1'b0}}, wait_pre};

  always_comb begin
    phase_nxt = grant ? rpra_pkg::PH_HOLD : phase_pre;
    wait_nxt  = wait_pre;
    if (cmd.tick && (phase_r == rpra_pkg::PH_HUNGRY) && (wait_r != rpra_pkg::WAIT_MAX)) begin
      wait_nxt = wait_r + 1'b1;
    end
    uses_nxt = uses_r;
    if (rel_eff && (uses_r != rpra_pkg::USE_MAX)) begin
      uses_nxt = uses_r + 1'b1;
    end
    sum_nxt = sum_r;
    if (grant) begin
      sum_nxt = sum_ext[rpra_pkg::SUM_W] ? rpra_pkg::SUM_MAX : sum_ext[rpra_pkg::SUM_W-1:0];
    end
    free_nxt = free_r;
    if (cmd.en && (grant || left.grant)) begin
      free_nxt = 1'b0;
    end else if (cmd.en && (rel_eff || left.released)) begin
      free_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= rpra_pkg::PH_IDLE;
      wait_r  <= '0;
      uses_r  <= '0;
      sum_r   <= '0;
      free_r  <= 1'b1;
    end else begin
      phase_r <= phase_nxt;
      wait_r  <= wait_nxt;
      uses_r  <= uses_nxt;
      sum_r   <= sum_nxt;
      free_r  <= free_nxt;
    end
  end

  assign link_o.phase      = phase_pre;
  assign link_o.wait_ticks = wait_pre;
  assign link_o.released   = rel_eff;
  assign link_o.grant      = grant;

  assign view_o.phase = phase_nxt;
  assign view_o.free  = free_nxt;
  assign view_o.uses  = uses_nxt;
  assign view_o.sum   = sum_nxt;

endmodule

// ----- src/ring_pair_resource_arbiter.sv -----
`timescale 1ns / 1ps
// Ring pair resource arbiter: a row of requester cells in a ring, each cell
// exchanging its phase and wait count with both neighbours as an item is taken.
// The result is registered and shows in the cycle after acceptance; one item per cycle
// is taken while the output is not stalled.
// Reset is synchronous, active low: all requesters idle, counts zero, resources free,
// active_count 5 and wait_threshold 3000. Depends on rpra_pkg and rpra_cell.
module ring_pair_resource_arbiter #(
  parameter int unsigned MAX_REQUESTERS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [rpra_pkg::OP_W-1:0]       in_operation,
  input  logic [rpra_pkg::REQ_W-1:0]      in_requester,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [rpra_pkg::MASK_W-1:0]     out_grant_mask,
  output logic [rpra_pkg::MASK_W-1:0]     out_holding_mask,
  output logic [rpra_pkg::MASK_W-1:0]     out_waiting_mask,
  output logic [rpra_pkg::MASK_W-1:0]     out_resource_free_mask,
  output logic [rpra_pkg::USE_W-1:0]      out_use_count,
  output logic [rpra_pkg::SUM_W-1:0]      out_total_wait,
  input  logic                            cfg_wr_en,
  input  logic                            cfg_index,
  input  logic [rpra_pkg::CFG_W-1:0]      cfg_wdata
);

  localparam int unsigned IDX_W = $clog2(MAX_REQUESTERS);
  localparam int unsigned CNT_W = $clog2(MAX_REQUESTERS + 1);
  localparam int unsigned CMP_W = (CNT_W > rpra_pkg::ACTIVE_W) ? CNT_W : rpra_pkg::ACTIVE_W;

  logic [rpra_pkg::ACTIVE_W-1:0] active_count_r;
  logic [rpra_pkg::WAIT_W-1:0]   wait_threshold_r;
  logic [CMP_W-1:0]              ring_n;
  logic [CMP_W-1:0]              ac_ext;
  logic [CMP_W-1:0]              req_ext;
  logic [IDX_W-1:0]              n_last;
  logic                          accept;
  logic                          req_in_ring;
  rpra_pkg::op_t                 op;

  rpra_pkg::cell_cmd_t  cmd_w   [MAX_REQUESTERS];
  rpra_pkg::cell_link_t link_w  [MAX_REQUESTERS];
  rpra_pkg::cell_link_t left_w  [MAX_REQUESTERS];
  rpra_pkg::cell_link_t right_w [MAX_REQUESTERS];
  rpra_pkg::cell_view_t view_w  [MAX_REQUESTERS];

  logic                          out_valid_r, out_valid_nxt;
  logic [rpra_pkg::MASK_W-1:0]   grant_nxt, hold_nxt, wait_nxt, free_nxt;
  logic [rpra_pkg::MASK_W-1:0]   grant_r, hold_r, wait_r, free_r;
  logic [rpra_pkg::USE_W-1:0]    use_nxt, use_r;
  logic [rpra_pkg::SUM_W-1:0]    sum_nxt, sum_r;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign op       = rpra_pkg::op_t'(in_operation);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_count_r   <= rpra_pkg::ACTIVE_RESET;
      wait_threshold_r <= rpra_pkg::THR_RESET;
    end else if (cfg_wr_en) begin
      unique case (rpra_pkg::cfg_idx_t'(cfg_index))
        rpra_pkg::CFG_ACTIVE_COUNT:   active_count_r   <= cfg_wdata[rpra_pkg::ACTIVE_W-1:0];
        rpra_pkg::CFG_WAIT_THRESHOLD: wait_threshold_r <= cfg_wdata[rpra_pkg::WAIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign ac_ext  = CMP_W'(active_count_r);
  assign req_ext = CMP_W'(in_requester);

  always_comb begin
    ring_n = ac_ext;
    if (ac_ext < CMP_W'(rpra_pkg::RING_MIN)) begin
      ring_n = CMP_W'(rpra_pkg::RING_MIN);
    end else if (ac_ext > CMP_W'(MAX_REQUESTERS)) begin
      ring_n = CMP_W'(MAX_REQUESTERS);
    end
  end

  assign n_last      = IDX_W'(ring_n - 1'b1);
  assign req_in_ring = req_ext < ring_n;

  for (genvar i = 0; i < MAX_REQUESTERS; i++) begin : g_cell
    logic en, self;
    assign en   = CMP_W'(i) < ring_n;
    assign self = (CMP_W'(i) == req_ext) && req_in_ring;

    assign cmd_w[i].en   = accept && en;
    assign cmd_w[i].tick = accept && en && (op == rpra_pkg::OP_TICK);
    assign cmd_w[i].req  = accept && self && (op == rpra_pkg::OP_REQUEST);
    assign cmd_w[i].rel  = accept && self && (op == rpra_pkg::OP_RELEASE);

    if (i == 0) begin : g_left_wrap
      assign left_w[i] = link_w[n_last];
    end else begin : g_left
      assign left_w[i] = link_w[i-1];
    end
    assign right_w[i] = (IDX_W'(i) == n_last) ? link_w[0]
                                               : link_w[(i + 1) % MAX_REQUESTERS];

    rpra_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd_w[i]),
      .threshold (wait_threshold_r),
      .left      (left_w[i]),
      .right     (right_w[i]),
      .link_o    (link_w[i]),
      .view_o    (view_w[i])
    );
  end

  for (genvar k = 0; k < rpra_pkg::MASK_W; k++) begin : g_mask
    if (k < MAX_REQUESTERS) begin : g_on
      assign grant_nxt[k] = link_w[k].grant;
      assign hold_nxt[k]  = view_w[k].phase == rpra_pkg::PH_HOLD;
      assign wait_nxt[k]  = view_w[k].phase == rpra_pkg::PH_HUNGRY;
      assign free_nxt[k]  = view_w[k].free;
    end else begin : g_off
      assign grant_nxt[k] = 1'b0;
      assign hold_nxt[k]  = 1'b0;
      assign wait_nxt[k]  = 1'b0;
      assign free_nxt[k]  = 1'b0;
    end
  end

  always_comb begin
    use_nxt = '0;
    sum_nxt = '0;
    for (int i = 0; i < MAX_REQUESTERS; i++) begin
      if (CMP_W'(i) == req_ext) begin
        use_nxt = view_w[i].uses;
        sum_nxt = view_w[i].sum;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      grant_r <= grant_nxt;
      hold_r  <= hold_nxt;
      wait_r  <= wait_nxt;
      free_r  <= free_nxt;
      use_r   <= use_nxt;
      sum_r   <= sum_nxt;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_grant_mask         = grant_r;
  assign out_holding_mask       = hold_r;
  assign out_waiting_mask       = wait_r;
  assign out_resource_free_mask = free_r;
  assign out_use_count          = use_r;
  assign out_total_wait         = sum_r;

`ifndef SYNTHESIS
  a_grant_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((grant_r & ~hold_r) == '0))
    else $error("granted requester not shown as holding");

  a_hold_not_hungry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((hold_r & wait_r) == '0))
    else $error("requester both holding and waiting");

  a_grant_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($countones(grant_r) <= 2))
    else $error("more than two grants from one item");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted item produced no result");
`endif

endmodule
